// ===== hdl/ppg_pkg.sv =====
package ppg_pkg;

	localparam int WINDOW_DEPTH = 128;
	localparam int SAMPLE_BITS  = 18;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] ir_sample;
		logic [SAMPLE_BITS-1:0] red_sample;
	} ppg_in_t;

	typedef struct packed {
		logic [14:0] spo2_level;
		logic        spo2_valid;
		logic        estimate_updated;
		logic [31:0] ir_smoothed;
	} ppg_out_t;

	localparam logic [0:0] CFG_FILTER_WEIGHT = 1'b0;
	localparam logic [0:0] CFG_SMOOTH_WEIGHT = 1'b1;

	localparam logic [15:0] FILTER_WEIGHT_RST = 16'd6554;
	localparam logic [15:0] SMOOTH_WEIGHT_RST = 16'd11796;

	localparam logic [14:0] RAW_BASE = 15'd28160;
	localparam logic [14:0] RAW_MIN  = 15'd17920;
	localparam logic [14:0] RAW_MAX  = 15'd25600;

	localparam int unsigned Q_BITS = 18;

endpackage

// ===== hdl/ppg_div.sv =====
module ppg_div import ppg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] num,
	input  logic [127:0] den,
	output logic         done,
	output logic [17:0]  quot
);
	logic [147:0] rem_q;
	logic [147:0] den_q;
	logic [17:0]  quot_q;
	logic [4:0]   step_q;
	logic         busy_q;
	logic [147:0] trial;
	logic [147:0] den_top;

	assign trial   = den_q << step_q;
	assign den_top = {20'd0, den} << Q_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 5'd17;
			end else if (busy_q) begin
				if (step_q == 5'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					step_q <= step_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {20'd0, num};
			den_q  <= {20'd0, den};
			quot_q <= ({20'd0, num} >= den_top) ? 18'h3FFFF : 18'd0;
		end else if (busy_q && quot_q != 18'h3FFFF) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				quot_q <= quot_q | (18'd1 << step_q);
			end
		end
	end

	assign quot = quot_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("divider not busy after start");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider restarted while busy");
endmodule

// ===== hdl/ppg_spo2_ratio_estimator_core.sv =====
// SpO2 ratio-of-ratios estimator. Each transaction carries one IR and one red
// sample and yields one result. Samples are low-pass filtered and stored in two
// WINDOW_DEPTH-entry memories (one read port each). Until the window fills, an
// item is filtered, written and passed to the output register. After that each
// item also makes one pass over the memories for the sums, one pass for the
// squared deviations (skipped if a sum is zero), a multiply, then an 18-step
// restoring divide for the ratio (skipped if the IR deviation sum is zero). No
// item is taken mid-work, and a result held by out_stall blocks the next one.
module ppg_spo2_ratio_estimator_core import ppg_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ppg_in_t        in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output ppg_out_t       out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [0:0]     cfg_index,
	input  logic [15:0]    cfg_data
);
	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int SW = 32 + AW;
	localparam int CW = AW + 1;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_FILT   = 4'd1;
	localparam logic [3:0] ST_WR     = 4'd2;
	localparam logic [3:0] ST_SUM    = 4'd3;
	localparam logic [3:0] ST_MEAN   = 4'd4;
	localparam logic [3:0] ST_AC     = 4'd5;
	localparam logic [3:0] ST_MUL    = 4'd6;
	localparam logic [3:0] ST_DIV    = 4'd7;
	localparam logic [3:0] ST_RAW    = 4'd8;
	localparam logic [3:0] ST_SMTH   = 4'd9;
	localparam logic [3:0] ST_OUT    = 4'd10;
	localparam logic [3:0] ST_MUL2   = 4'd11;
	localparam logic [3:0] ST_DSTART = 4'd12;

	logic [3:0]  state_q;
	logic [15:0] fw_q, sw_q;
	logic [31:0] ir_mem [WINDOW_DEPTH];
	logic [31:0] red_mem [WINDOW_DEPTH];
	logic [31:0] ir_rd_q, red_rd_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wpos_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] cnt_q;
	logic          rd_vld_q;
	logic          seeded_q;
	logic [31:0]   ir_f_q, red_f_q;
	logic [SAMPLE_BITS+13:0] ir_x, red_x;
	logic [SW-1:0] ir_sum_q, red_sum_q;
	logic [31:0]   ir_mean_q, red_mean_q;
	logic [63:0]   ir_ac_q, red_ac_q;
	logic [14:0]   spo2_q;
	logic          started_q, upd_q;
	logic [127:0]  num_q, den_q;
	logic [63:0]   pa_q, pb_q, pc_q, pd_q;
	logic          div_start, div_done;
	logic [17:0]   quot;
	logic [14:0]   raw_q;
	logic          out_full_q;
	ppg_out_t      out_q;

	assign cfg_ready = (state_q == ST_IDLE) && !out_full_q;
	assign in_stall  = (state_q != ST_IDLE) || out_full_q;
	assign out_valid = out_full_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FILTER_WEIGHT_RST;
			sw_q <= SMOOTH_WEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FILTER_WEIGHT: fw_q <= cfg_data;
				CFG_SMOOTH_WEIGHT: sw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [31:0] lowpass(input logic [15:0] w,
		input logic [SAMPLE_BITS+13:0] x, input logic [31:0] p);
		logic [16:0] wc;
		logic [SAMPLE_BITS+32:0] v;
		begin
			wc = 17'd65536 - {1'b0, w};
			v = (SAMPLE_BITS+33)'(w) * (SAMPLE_BITS+33)'(x)
				+ (SAMPLE_BITS+33)'(wc) * (SAMPLE_BITS+33)'(p)
				+ (SAMPLE_BITS+33)'(32768);
			v = v >> 16;
			lowpass = (v > (SAMPLE_BITS+33)'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : v[31:0];
		end
	endfunction

	function automatic logic [31:0] sat32(input logic [SAMPLE_BITS+13:0] x);
		begin
			sat32 = (x > (SAMPLE_BITS+14)'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : 32'(x);
		end
	endfunction

	assign ir_x  = {in_data.ir_sample[SAMPLE_BITS-1:0], 14'd0};
	assign red_x = {in_data.red_sample[SAMPLE_BITS-1:0], 14'd0};

	logic [SAMPLE_BITS+13:0] ir_x_q, red_x_q;
	logic [31:0] ir_d, red_d;
	logic [63:0] ir_sq, red_sq;

	assign rd_addr = cnt_q[AW-1:0];
	assign ir_d  = (ir_rd_q >= ir_mean_q) ? ir_rd_q - ir_mean_q : ir_mean_q - ir_rd_q;
	assign red_d = (red_rd_q >= red_mean_q) ? red_rd_q - red_mean_q : red_mean_q - red_rd_q;
	assign ir_sq  = 64'(ir_d) * 64'(ir_d);
	assign red_sq = 64'(red_d) * 64'(red_d);

	always_ff @(posedge clk) begin
		if (state_q == ST_WR) begin
			ir_mem[wpos_q]  <= ir_f_q;
			red_mem[wpos_q] <= red_f_q;
		end
		ir_rd_q  <= ir_mem[rd_addr];
		red_rd_q <= red_mem[rd_addr];
	end

	assign div_start = (state_q == ST_DSTART);

	ppg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (quot)
	);

	logic [14:0] raw_c;
	logic [15:0] scaled;
	logic [22:0] q25;
	assign q25    = 23'(quot) * 23'd25 + 23'd128;
	assign scaled = q25[22:8] + 16'd0;
	always_comb begin
		if ({1'b0, scaled} > 17'(RAW_BASE - RAW_MIN)) raw_c = RAW_MIN;
		else if (RAW_BASE - scaled[14:0] > RAW_MAX) raw_c = RAW_MAX;
		else raw_c = RAW_BASE - scaled[14:0];
	end

	logic [16:0] swc;
	logic [32:0] smth;
	assign swc  = 17'd65536 - {1'b0, sw_q};
	assign smth = (33'(sw_q) * 33'(raw_q) + 33'(swc) * 33'(spo2_q) + 33'd32768) >> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			seeded_q   <= 1'b0;
			wpos_q     <= '0;
			fill_q     <= '0;
			cnt_q      <= '0;
			rd_vld_q   <= 1'b0;
			spo2_q     <= '0;
			started_q  <= 1'b0;
			upd_q      <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			if (out_full_q && !out_stall) out_full_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						ir_x_q  <= ir_x;
						red_x_q <= red_x;
						state_q <= ST_FILT;
					end
				end
				ST_FILT: begin
					if (!seeded_q) begin
						ir_f_q  <= sat32(ir_x_q);
						red_f_q <= sat32(red_x_q);
					end else begin
						ir_f_q  <= lowpass(fw_q, ir_x_q, ir_f_q);
						red_f_q <= lowpass(fw_q, red_x_q, red_f_q);
					end
					seeded_q <= 1'b1;
					state_q  <= ST_WR;
				end
				ST_WR: begin
					wpos_q <= (wpos_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
					upd_q  <= 1'b0;
					cnt_q  <= '0;
					rd_vld_q <= 1'b0;
					ir_sum_q <= '0;
					red_sum_q <= '0;
					if (fill_q == CW'(WINDOW_DEPTH)) begin
						state_q <= ST_SUM;
					end else begin
						fill_q  <= fill_q + 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_SUM: begin
					if (rd_vld_q) begin
						ir_sum_q  <= ir_sum_q + SW'(ir_rd_q);
						red_sum_q <= red_sum_q + SW'(red_rd_q);
					end
					rd_vld_q <= (cnt_q != CW'(WINDOW_DEPTH));
					if (cnt_q == CW'(WINDOW_DEPTH)) begin
						cnt_q   <= '0;
						state_q <= ST_MEAN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MEAN: begin
					ir_mean_q  <= 32'(ir_sum_q >> AW);
					red_mean_q <= 32'(red_sum_q >> AW);
					ir_ac_q    <= '0;
					red_ac_q   <= '0;
					rd_vld_q   <= 1'b0;
					if (ir_sum_q == '0 || red_sum_q == '0) state_q <= ST_OUT;
					else state_q <= ST_AC;
				end
				ST_AC: begin
					if (rd_vld_q) begin
						ir_ac_q  <= ir_ac_q + (ir_sq >> 14);
						red_ac_q <= red_ac_q + (red_sq >> 14);
					end
					rd_vld_q <= (cnt_q != CW'(WINDOW_DEPTH));
					if (cnt_q == CW'(WINDOW_DEPTH)) begin
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (ir_ac_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						pa_q <= 64'(red_ac_q[31:0]) * 64'(ir_sum_q[31:0]);
						pb_q <= 64'(red_ac_q[63:32]) * 64'(ir_sum_q[31:0]);
						pc_q <= 64'(red_sum_q[31:0]) * 64'(ir_ac_q[31:0]);
						pd_q <= 64'(red_sum_q[31:0]) * 64'(ir_ac_q[63:32]);
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					state_q <= ST_DSTART;
				end
				ST_DSTART: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						raw_q   <= raw_c;
						state_q <= ST_SMTH;
					end
				end
				ST_SMTH: begin
					spo2_q    <= started_q ? smth[14:0] : raw_q;
					started_q <= 1'b1;
					upd_q     <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_OUT) out_full_q <= 1'b1;
		end
	end

	logic [AW-1:0] ir_sum_hi, red_sum_hi;
	assign ir_sum_hi  = ir_sum_q[SW-1:32];
	assign red_sum_hi = red_sum_q[SW-1:32];

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL2) begin
			num_q <= (128'(pa_q) + (128'(pb_q) << 32)
				+ ((128'(red_ac_q) * 128'(ir_sum_hi)) << 32)) << 16;
			den_q <= 128'(pc_q) + (128'(pd_q) << 32)
				+ ((128'(ir_ac_q) * 128'(red_sum_hi)) << 32);
		end
		if (state_q == ST_OUT) begin
			out_q.spo2_level       <= spo2_q;
			out_q.spo2_valid       <= started_q;
			out_q.estimate_updated <= upd_q;
			out_q.ir_smoothed      <= ir_f_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_FILT))
		else $error("accepted transaction did not start filtering");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (fill_q == CW'(WINDOW_DEPTH)))
		else $error("estimate started before window filled");
	assert property (@(posedge clk) disable iff (!arst_n)
		upd_q && out_full_q |-> started_q)
		else $error("update flagged without an estimate");
	assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> (spo2_q >= RAW_MIN && spo2_q <= RAW_MAX))
		else $error("spo2 out of range");
endmodule
